[rtl/acs_pkg.sv]
// Shared types, codes and helpers for the accumulator processor step block.
package acs_pkg;

  // Input transaction operations
  typedef enum logic [1:0] {
    OP_PROG = 2'd0,
    OP_DATA = 2'd1,
    OP_EXEC = 2'd2,
    OP_READ = 2'd3
  } acs_op_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_OUT  = 2'd1,
    KIND_HALT = 2'd2,
    KIND_READ = 2'd3
  } acs_kind_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_READ
  } acs_state_t;

  // Instruction opcodes
  localparam logic [7:0] OPC_AND = 8'h01;
  localparam logic [7:0] OPC_OR  = 8'h02;
  localparam logic [7:0] OPC_XOR = 8'h03;
  localparam logic [7:0] OPC_NOT = 8'h04;
  localparam logic [7:0] OPC_LDA = 8'h05;
  localparam logic [7:0] OPC_STA = 8'h06;
  localparam logic [7:0] OPC_HLT = 8'h07;
  localparam logic [7:0] OPC_TST = 8'h08;
  localparam logic [7:0] OPC_JPZ = 8'h09;
  localparam logic [7:0] OPC_ADD = 8'h0A;
  localparam logic [7:0] OPC_OUT = 8'h0B;
  localparam logic [7:0] OPC_JMP = 8'h0C;

  // Outcome of one executed instruction
  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] pc;
    logic       halt;
    logic       st_en;
    acs_kind_t  kind;
    logic [7:0] value;
  } acs_exec_t;

  // Remainder of a byte by a store depth d, with m = ceil(2^16 / d).
  // The quotient estimate (a * m) >> 16 is exact for any byte and d up to 256.
  function automatic logic [7:0] acs_mod(input logic [7:0] a, input logic [8:0] d,
                                         input logic [16:0] m);
    logic [24:0] prod;
    logic [16:0] qd;
    prod = {17'd0, a} * {8'd0, m};
    qd   = {9'd0, prod[23:16]} * {8'd0, d};
    return 8'({9'd0, a} - qd);
  endfunction

endpackage

[rtl/acs_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module acs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/acs_alu.sv]
// Instruction decode and accumulator datapath for one fetched instruction.
module acs_alu import acs_pkg::*; (
  input  logic [7:0] opcode,
  input  logic [7:0] operand,
  input  logic [7:0] mem,
  input  logic [7:0] acc,
  input  logic [7:0] pc_inc,
  output acs_exec_t  res
);

  always_comb begin
    res       = '0;
    res.acc   = acc;
    res.pc    = pc_inc;
    res.halt  = 1'b0;
    res.st_en = 1'b0;
    res.kind  = KIND_ACK;
    res.value = 8'd0;
    unique case (opcode)
      OPC_AND: res.acc = acc & mem;
      OPC_OR:  res.acc = acc | mem;
      OPC_XOR: res.acc = acc ^ mem;
      OPC_NOT: res.acc = ~acc;
      OPC_LDA: res.acc = mem;
      OPC_STA: res.st_en = 1'b1;
      OPC_HLT: begin
        res.halt = 1'b1;
        res.kind = KIND_HALT;
      end
      OPC_TST: begin
        if (acc == mem) begin
          res.acc = 8'd0;
        end
      end
      OPC_JPZ: begin
        if (acc == 8'd0) begin
          res.pc = operand;
        end
      end
      OPC_ADD: res.acc = acc + mem;
      OPC_OUT: begin
        res.kind  = KIND_OUT;
        res.value = acc;
      end
      OPC_JMP: res.pc = operand;
      default: ;  // unknown opcode: no effect
    endcase
  end

endmodule

[rtl/accumulator_cpu_step.sv]
// Accumulator processor step: program/data loads, data reads, one instruction per execute.
// One transaction is buffered while the core works. An execute steps through program RAM read,
//   data RAM read and execute/write-back; a data read through data RAM read and result load;
//   loads and halted steps complete as they leave the buffer. Results wait for a free result register.
// Reset (rst_n low, synchronous): accumulator, PC and halt flag clear; buffers empty.
// Program and data RAMs are not cleared; they hold garbage until written.
module accumulator_cpu_step import acs_pkg::*; #(
  parameter int PROGRAM_DEPTH = 256,
  parameter int DATA_DEPTH    = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [7:0]        in_addr,
  input  logic [7:0]        in_wdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic signed [7:0] out_value,
  output logic [7:0]        out_pc,
  output logic              out_halted
);

  localparam int PAW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
  localparam int DAW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam logic [8:0] PDEPTH = 9'(PROGRAM_DEPTH);
  localparam logic [8:0] DDEPTH = 9'(DATA_DEPTH);
  // Reciprocals for the address reduction, ceil(2^16 / depth)
  localparam logic [16:0] PRECIP = 17'((65536 + PROGRAM_DEPTH - 1) / PROGRAM_DEPTH);
  localparam logic [16:0] DRECIP = 17'((65536 + DATA_DEPTH - 1) / DATA_DEPTH);

  // Input transaction buffer: frees the input side while the core works
  logic       buf_vld_r, buf_vld_nxt;
  acs_op_t    buf_op_r;
  logic [7:0] buf_addr_r;
  logic [7:0] buf_wdata_r;

  // Architectural state
  acs_state_t state_r, state_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic [7:0] pc_r, pc_nxt;
  logic       halt_r, halt_nxt;

  // Result register
  logic       out_vld_r, out_vld_nxt;
  acs_kind_t  out_kind_r;
  logic [7:0] out_value_r;
  logic [7:0] out_pc_r;
  logic       out_halted_r;

  // Control
  logic       take;
  logic       res_load;
  acs_kind_t  res_kind;
  logic [7:0] res_value;
  logic       out_free;
  logic       end_hit;
  logic [7:0] pc_inc;

  // Memory ports
  logic           prog_we, prog_re;
  logic [PAW-1:0] prog_waddr, prog_raddr_lo, prog_raddr_hi;
  logic [7:0]     opcode, operand;
  logic           data_we, data_re;
  logic [DAW-1:0] data_waddr, data_raddr;
  logic [7:0]     data_wdata, data_rdata;
  logic [7:0]     buf_paddr, buf_daddr, opnd_daddr;

  acs_exec_t      alu_res;

  // Buffer refills in the same cycle it hands its transaction to the core
  assign in_ready = !buf_vld_r || take;
  assign out_free = !out_vld_r || out_ready;
  assign end_hit  = ({1'b0, pc_r} + 9'd2) >= PDEPTH;
  assign pc_inc   = pc_r + 8'd2;

  // Store addresses reduced modulo the store depths
  assign buf_paddr  = acs_mod(buf_addr_r, PDEPTH, PRECIP);
  assign buf_daddr  = acs_mod(buf_addr_r, DDEPTH, DRECIP);
  assign opnd_daddr = acs_mod(operand, DDEPTH, DRECIP);

  // Program store is kept twice so the opcode and operand bytes come out together
  assign prog_waddr    = buf_paddr[PAW-1:0];
  assign prog_raddr_lo = pc_r[PAW-1:0];
  assign prog_raddr_hi = PAW'(pc_r + 8'd1);

  acs_ram #(.WIDTH(8), .DEPTH(PROGRAM_DEPTH)) u_prog_lo (
    .clk   (clk),
    .we    (prog_we),
    .waddr (prog_waddr),
    .wdata (buf_wdata_r),
    .re    (prog_re),
    .raddr (prog_raddr_lo),
    .rdata (opcode)
  );

  acs_ram #(.WIDTH(8), .DEPTH(PROGRAM_DEPTH)) u_prog_hi (
    .clk   (clk),
    .we    (prog_we),
    .waddr (prog_waddr),
    .wdata (buf_wdata_r),
    .re    (prog_re),
    .raddr (prog_raddr_hi),
    .rdata (operand)
  );

  acs_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_data (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .re    (data_re),
    .raddr (data_raddr),
    .rdata (data_rdata)
  );

  acs_alu u_alu (
    .opcode  (opcode),
    .operand (operand),
    .mem     (data_rdata),
    .acc     (acc_r),
    .pc_inc  (pc_inc),
    .res     (alu_res)
  );

  // Next state. Program and data RAM outputs hold while a state waits on the
  // result register, since no new read is issued until the state advances.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (buf_vld_r && out_free) begin
          unique case (buf_op_r)
            OP_EXEC: begin
              if (!halt_r && !end_hit) begin
                state_nxt = ST_FETCH;
              end
            end
            OP_READ: state_nxt = ST_READ;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FETCH: state_nxt = ST_EXEC;
      ST_EXEC:  if (out_free) state_nxt = ST_IDLE;
      ST_READ:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: memory strobes, state update, result load
  always_comb begin
    take       = 1'b0;
    prog_we    = 1'b0;
    prog_re    = 1'b0;
    data_we    = 1'b0;
    data_re    = 1'b0;
    data_waddr = buf_daddr[DAW-1:0];
    data_wdata = buf_wdata_r;
    data_raddr = buf_daddr[DAW-1:0];
    res_load   = 1'b0;
    res_kind   = KIND_ACK;
    res_value  = 8'd0;
    acc_nxt    = acc_r;
    pc_nxt     = pc_r;
    halt_nxt   = halt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (buf_vld_r && out_free) begin
          take = 1'b1;
          unique case (buf_op_r)
            OP_PROG: begin
              prog_we  = 1'b1;
              res_load = 1'b1;
            end
            OP_DATA: begin
              data_we  = 1'b1;
              res_load = 1'b1;
            end
            OP_EXEC: begin
              if (halt_r) begin
                res_load = 1'b1;
              end else if (end_hit) begin
                halt_nxt = 1'b1;
                res_kind = KIND_HALT;
                res_load = 1'b1;
              end else begin
                prog_re = 1'b1;
              end
            end
            OP_READ: data_re = 1'b1;
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        // operand byte is out of the program RAM: fetch the data byte
        data_re    = 1'b1;
        data_raddr = opnd_daddr[DAW-1:0];
      end
      ST_EXEC: begin
        if (out_free) begin
          acc_nxt    = alu_res.acc;
          pc_nxt     = alu_res.pc;
          halt_nxt   = alu_res.halt;
          data_we    = alu_res.st_en;
          data_waddr = opnd_daddr[DAW-1:0];
          data_wdata = acc_r;
          res_kind   = alu_res.kind;
          res_value  = alu_res.value;
          res_load   = 1'b1;
        end
      end
      ST_READ: begin
        if (out_free) begin
          res_kind  = KIND_READ;
          res_value = data_rdata;
          res_load  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign buf_vld_nxt = (in_valid && in_ready) || (buf_vld_r && !take);
  assign out_vld_nxt = res_load || (out_vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= ST_IDLE;
      acc_r     <= 8'd0;
      pc_r      <= 8'd0;
      halt_r    <= 1'b0;
    end else begin
      buf_vld_r <= buf_vld_nxt;
      out_vld_r <= out_vld_nxt;
      state_r   <= state_nxt;
      acc_r     <= acc_nxt;
      pc_r      <= pc_nxt;
      halt_r    <= halt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      buf_op_r    <= acs_op_t'(in_op);
      buf_addr_r  <= in_addr;
      buf_wdata_r <= in_wdata;
    end
    if (res_load) begin
      out_kind_r   <= res_kind;
      out_value_r  <= res_value;
      out_pc_r     <= pc_nxt;
      out_halted_r <= halt_nxt;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_kind   = out_kind_r;
  assign out_value  = out_value_r;
  assign out_pc     = out_pc_r;
  assign out_halted = out_halted_r;

  // Halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag cleared without reset");

  // PC only moves together with a transaction result
  a_pc_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    !res_load |=> pc_r == $past(pc_r))
    else $error("pc changed without a result");

  // A result comes from a buffered transaction or a finishing core state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (take || state_r == ST_EXEC || state_r == ST_READ))
    else $error("result produced with no transaction");

  // No data store write while a data read is in flight
  a_no_write_mid_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH || state_r == ST_READ) |-> !data_we)
    else $error("data store written during a read");

endmodule

[tb/tb.sv]
// Self-checking testbench for the accumulator processor step block.
module tb;
  import acs_pkg::*;

  localparam int PROG_DEPTH   = 256;
  localparam int DATA_DEPTH   = 16;
  localparam int RANDOM_ITEMS = 1800;
  // Worst case is under 1.9k transactions, each seeing a sender gap, a stalled
  // receiver and the execute path; this limit is several times that.
  localparam int CYCLE_LIMIT  = 400000;

  // One result transaction as the block reports it
  typedef struct packed {
    acs_kind_t  kind;
    logic [7:0] value;
    logic [7:0] pc;
    logic       halted;
  } step_result_t;

  // One row of the directed table; typed rows carry their own expected result
  typedef struct packed {
    acs_op_t      op;
    logic [7:0]   addr;
    logic [7:0]   wdata;
    logic         typed;
    step_result_t res;
  } vector_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_op = 2'd0;
  logic [7:0]        in_addr = 8'd0;
  logic [7:0]        in_wdata = 8'd0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_kind;
  logic signed [7:0] out_value;
  logic [7:0]        out_pc;
  logic              out_halted;

  accumulator_cpu_step #(
    .PROGRAM_DEPTH(PROG_DEPTH),
    .DATA_DEPTH   (DATA_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_addr   (in_addr),
    .in_wdata  (in_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_value (out_value),
    .out_pc    (out_pc),
    .out_halted(out_halted)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the processor state
  logic [7:0] shadow_acc;
  logic [7:0] shadow_pc;
  logic       shadow_halt;
  logic [7:0] shadow_prog [PROG_DEPTH];
  logic [7:0] shadow_data [DATA_DEPTH];
  // Which store entries hold a written byte; unwritten ones must never be fetched
  bit         prog_valid [PROG_DEPTH];
  bit         data_valid [DATA_DEPTH];

  step_result_t due_results[$];
  vector_row_t  dir_rows[$];
  int           fail_cnt = 0;
  int           cycle_cnt = 0;
  int           items_sent = 0;
  int           burst_left = 0;
  int           ready_mode = 0;
  int           ready_left = 0;

  // Advances the shadow state by one input transaction and returns its result.
  function automatic step_result_t cpu_step_result(acs_op_t op, logic [7:0] addr,
                                                   logic [7:0] wdata);
    step_result_t r;
    logic [7:0]   opc;
    logic [7:0]   opd;
    logic [7:0]   mem;
    int           di;
    r.kind  = KIND_ACK;
    r.value = 8'd0;
    case (op)
      OP_PROG: shadow_prog[addr % PROG_DEPTH] = wdata;
      OP_DATA: shadow_data[addr % DATA_DEPTH] = wdata;
      OP_READ: begin
        r.kind  = KIND_READ;
        r.value = shadow_data[addr % DATA_DEPTH];
      end
      default: begin
        if (!shadow_halt) begin
          if (int'(shadow_pc) + 2 >= PROG_DEPTH) begin
            // ran off the end of the program: halt, nothing else moves
            shadow_halt = 1'b1;
            r.kind      = KIND_HALT;
          end else begin
            opc       = shadow_prog[shadow_pc % PROG_DEPTH];
            opd       = shadow_prog[(int'(shadow_pc) + 1) % PROG_DEPTH];
            shadow_pc = shadow_pc + 8'd2;
            di        = opd % DATA_DEPTH;
            mem       = shadow_data[di];
            case (opc)
              OPC_AND: shadow_acc = shadow_acc & mem;
              OPC_OR:  shadow_acc = shadow_acc | mem;
              OPC_XOR: shadow_acc = shadow_acc ^ mem;
              OPC_NOT: shadow_acc = ~shadow_acc;
              OPC_LDA: shadow_acc = mem;
              OPC_STA: shadow_data[di] = shadow_acc;
              OPC_HLT: begin
                shadow_halt = 1'b1;
                r.kind      = KIND_HALT;
              end
              OPC_TST: if (shadow_acc == mem) shadow_acc = 8'd0;
              OPC_JPZ: if (shadow_acc == 8'd0) shadow_pc = opd;
              OPC_ADD: shadow_acc = shadow_acc + mem;
              OPC_OUT: begin
                r.kind  = KIND_OUT;
                r.value = shadow_acc;
              end
              OPC_JMP: shadow_pc = opd;
              default: ;
            endcase
          end
        end
      end
    endcase
    r.pc     = shadow_pc;
    r.halted = shadow_halt;
    return r;
  endfunction

  function automatic vector_row_t vec(acs_op_t op, logic [7:0] addr, logic [7:0] wdata,
                                      logic typed, acs_kind_t kind, logic [7:0] value,
                                      logic [7:0] pc, logic halted);
    vector_row_t v;
    v.op         = op;
    v.addr       = addr;
    v.wdata      = wdata;
    v.typed      = typed;
    v.res.kind   = kind;
    v.res.value  = value;
    v.res.pc     = pc;
    v.res.halted = halted;
    return v;
  endfunction

  // Data bytes lean toward zero and the sign extremes so that JPZ, TST and
  // the wrapping add see their interesting cases often.
  function automatic logic [7:0] rand_byte();
    int sel;
    sel = $urandom_range(99);
    if (sel < 20) return 8'h00;
    if (sel < 28) return 8'hFF;
    if (sel < 33) return 8'h80;
    if (sel < 38) return 8'h7F;
    return 8'($urandom);
  endfunction

  // Opcode for a fresh instruction; never HLT while the machine must keep running.
  function automatic logic [7:0] pick_opcode();
    logic [7:0] junk;
    if ($urandom_range(99) < 10) begin
      junk = 8'($urandom);
      return (junk == OPC_HLT) ? 8'h00 : junk;
    end
    case ($urandom_range(10))
      0:       return OPC_AND;
      1:       return OPC_OR;
      2:       return OPC_XOR;
      3:       return OPC_NOT;
      4:       return OPC_LDA;
      5:       return OPC_STA;
      6:       return OPC_TST;
      7:       return OPC_JPZ;
      8:       return OPC_ADD;
      9:       return OPC_OUT;
      default: return OPC_JMP;
    endcase
  endfunction

  // Drives one transaction and holds it until accepted. Valid is dropped only
  // when a gap is actually inserted, so it never gets two updates in one step.
  task automatic send_item(input acs_op_t op, input logic [7:0] addr, input logic [7:0] wdata,
                           input logic typed, input step_result_t typed_res);
    step_result_t r;
    int           gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    r = cpu_step_result(op, addr, wdata);
    if (op == OP_PROG) prog_valid[addr % PROG_DEPTH] = 1'b1;
    if (op == OP_DATA) data_valid[addr % DATA_DEPTH] = 1'b1;
    due_results.push_back(typed ? typed_res : r);
    items_sent++;
    in_valid <= 1'b1;
    in_op    <= op;
    in_addr  <= addr;
    in_wdata <= wdata;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send(input acs_op_t op, input logic [7:0] addr, input logic [7:0] wdata);
    send_item(op, addr, wdata, 1'b0, '0);
  endtask

  // Make sure the data entry an operand points at has been written.
  task automatic need_data(input logic [7:0] a);
    if (!data_valid[a % DATA_DEPTH]) send(OP_DATA, a, rand_byte());
  endtask

  // Writes a two-byte instruction at the given address. Jump targets stay
  // below 254 so the program cannot run off its end by a jump.
  task automatic plant_instr(input logic [7:0] at, input logic [7:0] opc);
    logic [7:0] opd;
    opd = (opc == OPC_JMP || opc == OPC_JPZ) ? 8'($urandom_range(253)) : 8'($urandom);
    // half the TST instructions get a matching data byte so the clear happens
    if (opc == OPC_TST && $urandom_range(1) == 1) send(OP_DATA, opd, shadow_acc);
    send(OP_PROG, at, opc);
    send(OP_PROG, at + 8'd1, opd);
  endtask

  // One execute transaction, with the program and data patched beforehand so
  // that nothing unwritten is fetched and the machine does not halt.
  task automatic run_step();
    logic [7:0] p;
    logic [7:0] opc;
    logic [7:0] opd;
    p = shadow_pc;
    if (p >= 8'd250) begin
      // near the end: bounce back before pc + 2 reaches the program size
      plant_instr(p, OPC_JMP);
    end else if (!prog_valid[p] || !prog_valid[p + 8'd1] || $urandom_range(99) < 40) begin
      plant_instr(p, pick_opcode());
    end else begin
      opc = shadow_prog[p];
      opd = shadow_prog[p + 8'd1];
      if (opc == OPC_HLT || ((opc == OPC_JMP || opc == OPC_JPZ) && opd >= 8'd254))
        plant_instr(p, pick_opcode());
    end
    need_data(shadow_prog[p + 8'd1]);
    send(OP_EXEC, 8'($urandom), 8'($urandom));
  endtask

  // Lowers valid and waits until every outstanding result has come back.
  task automatic drain();
    in_valid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  // Receiver: stall pattern is redrawn whenever its countdown runs out, among always
  // ready, coin flip, mostly stalled and a three-in-four cadence.
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(3);
      ready_left <= $urandom_range(20, 200);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(1) == 0);
      2:       out_ready <= ($urandom_range(3) == 0);
      default: out_ready <= ((cycle_cnt % 4) != 3);
    endcase
  end

  // Result checker and watchdog. Outputs are sampled at the edge, before any
  // update made in this time step takes effect.
  always @(posedge clk) begin
    step_result_t head;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result transaction with none expected: kind %0d pc %0d", out_kind, out_pc);
        fail_cnt++;
      end else begin
        head = due_results.pop_front();
        if (out_kind !== head.kind) begin
          $error("kind: expected %0d, got %0d", head.kind, out_kind);
          fail_cnt++;
        end
        if (out_value !== head.value) begin
          $error("value: expected %0d, got %0d", $signed(head.value), out_value);
          fail_cnt++;
        end
        if (out_pc !== head.pc) begin
          $error("pc: expected %0d, got %0d", head.pc, out_pc);
          fail_cnt++;
        end
        if (out_halted !== head.halted) begin
          $error("halted: expected %0d, got %0d", head.halted, out_halted);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    logic [7:0] a;
    int         sel;
    bit         paused;
    paused      = 1'b0;
    shadow_acc  = 8'd0;
    shadow_pc   = 8'd0;
    shadow_halt = 1'b0;

    // Directed table. Program: LDA 255 (entry 15), ADD 1 (-128, wraps to 127),
    // OUT, TST 2 (equal, clears), JPZ 0 (taken). Then an unknown opcode.
    dir_rows = '{
      vec(OP_DATA, 8'h00, 8'h00, 1'b1, KIND_ACK,  8'h00, 8'd0, 1'b0),
      vec(OP_DATA, 8'hFF, 8'hFF, 1'b1, KIND_ACK,  8'h00, 8'd0, 1'b0), // aliases entry 15
      vec(OP_DATA, 8'h31, 8'h80, 1'b1, KIND_ACK,  8'h00, 8'd0, 1'b0), // entry 1
      vec(OP_DATA, 8'h02, 8'h7F, 1'b1, KIND_ACK,  8'h00, 8'd0, 1'b0),
      vec(OP_READ, 8'h0F, 8'hA5, 1'b1, KIND_READ, 8'hFF, 8'd0, 1'b0),
      vec(OP_READ, 8'hF1, 8'h5A, 1'b1, KIND_READ, 8'h80, 8'd0, 1'b0),
      vec(OP_PROG, 8'h00, OPC_LDA, 1'b1, KIND_ACK, 8'h00, 8'd0, 1'b0),
      vec(OP_PROG, 8'h01, 8'hFF,   1'b1, KIND_ACK, 8'h00, 8'd0, 1'b0),
      vec(OP_PROG, 8'h02, OPC_ADD, 1'b1, KIND_ACK, 8'h00, 8'd0, 1'b0),
      vec(OP_PROG, 8'h03, 8'h01,   1'b1, KIND_ACK, 8'h00, 8'd0, 1'b0),
      vec(OP_PROG, 8'h04, OPC_OUT, 1'b1, KIND_ACK, 8'h00, 8'd0, 1'b0),
      vec(OP_PROG, 8'h05, 8'h00,   1'b1, KIND_ACK, 8'h00, 8'd0, 1'b0),
      vec(OP_PROG, 8'h06, OPC_TST, 1'b1, KIND_ACK, 8'h00, 8'd0, 1'b0),
      vec(OP_PROG, 8'h07, 8'h02,   1'b1, KIND_ACK, 8'h00, 8'd0, 1'b0),
      vec(OP_PROG, 8'h08, OPC_JPZ, 1'b1, KIND_ACK, 8'h00, 8'd0, 1'b0),
      vec(OP_PROG, 8'h09, 8'h00,   1'b1, KIND_ACK, 8'h00, 8'd0, 1'b0),
      vec(OP_EXEC, 8'hFF, 8'h00, 1'b1, KIND_ACK, 8'h00, 8'd2, 1'b0),
      vec(OP_EXEC, 8'h00, 8'hFF, 1'b1, KIND_ACK, 8'h00, 8'd4, 1'b0),
      vec(OP_EXEC, 8'hAA, 8'h55, 1'b1, KIND_OUT, 8'h7F, 8'd6, 1'b0),
      vec(OP_EXEC, 8'h55, 8'hAA, 1'b1, KIND_ACK, 8'h00, 8'd8, 1'b0),
      vec(OP_EXEC, 8'h00, 8'h00, 1'b1, KIND_ACK, 8'h00, 8'd0, 1'b0),
      vec(OP_PROG, 8'hFF, 8'h00, 1'b1, KIND_ACK, 8'h00, 8'd0, 1'b0),
      vec(OP_PROG, 8'h00, 8'hFF, 1'b0, KIND_ACK, 8'h00, 8'd0, 1'b0), // unknown opcode
      vec(OP_EXEC, 8'h00, 8'h00, 1'b0, KIND_ACK, 8'h00, 8'd0, 1'b0),
      vec(OP_READ, 8'h00, 8'hFF, 1'b0, KIND_ACK, 8'h00, 8'd0, 1'b0)
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].wdata,
                dir_rows[i].typed, dir_rows[i].res);

    // Random part: mostly execute transactions on a program patched just in
    // time, mixed with stray program/data writes and reads.
    while (items_sent < dir_rows.size() + RANDOM_ITEMS) begin
      if (!paused && items_sent >= dir_rows.size() + RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        drain();
      end
      sel = $urandom_range(99);
      if (sel < 50) begin
        run_step();
      end else if (sel < 65) begin
        send(OP_PROG, 8'($urandom), rand_byte());
      end else if (sel < 80) begin
        send(OP_DATA, 8'($urandom), rand_byte());
      end else begin
        a = 8'($urandom);
        need_data(a);
        send(OP_READ, a, 8'($urandom));
      end
    end

    // Halting tail: a halt can never be undone, so only one way to halt per
    // run, chosen at random: the HLT opcode, or a jump past the program end.
    a = shadow_pc;
    if ($urandom_range(1) == 1) begin
      send(OP_PROG, a, OPC_HLT);
      send(OP_PROG, a + 8'd1, 8'($urandom));
      need_data(shadow_prog[a + 8'd1]);
      send(OP_EXEC, 8'($urandom), 8'($urandom));
    end else begin
      send(OP_PROG, a, OPC_JMP);
      send(OP_PROG, a + 8'd1, 8'hFE | 8'($urandom_range(1)));
      need_data(shadow_prog[a + 8'd1]);
      send(OP_EXEC, 8'($urandom), 8'($urandom));
      // pc now at 254 or 255: this step hits the end-of-program rule
      send(OP_EXEC, 8'($urandom), 8'($urandom));
    end
    // While halted, steps change nothing; loads and reads still work.
    repeat (3) send(OP_EXEC, 8'($urandom), 8'($urandom));
    a = 8'($urandom);
    send(OP_DATA, a, rand_byte());
    send(OP_READ, a, 8'($urandom));
    send(OP_PROG, 8'($urandom), 8'($urandom));
    send(OP_EXEC, 8'($urandom), 8'($urandom));

    drain();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
